FILE: design/prefix_varint_stream_writer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the varint stream writer
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef PREFIX_VARINT_STREAM_WRITER_DEFINES_SVH
`define PREFIX_VARINT_STREAM_WRITER_DEFINES_SVH

// Same-cycle implication.
`define PVSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PVSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pvsw_pkg.sv
// ---------------------------------------------------------------------------
// Varint stream writer package
// Item kinds, byte command format and fixed constants.
// ---------------------------------------------------------------------------
package pvsw_pkg;

  // Widest alignment a gap may ask for, as log2 of bytes.
  localparam int unsigned MaxAlignLog2 = 6;
  // Byte count of one command: up to 2^MaxAlignLog2 - 1 pad bytes.
  localparam int unsigned LenW = 6;

  localparam logic [7:0] PadByte = 8'hCC;

  typedef enum logic [1:0] {
    KIND_VARINT = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_PAD    = 2'd2
  } kind_e;

  // One queued command: a run of len bytes.
  typedef struct packed {
    logic            pad;    // every byte is the pad byte
    logic [7:0]      first;  // first byte
    logic [63:0]     rest;   // following bytes, MSB-aligned, sent high first
    logic [LenW-1:0] len;    // total bytes, never zero
  } cmd_t;

endpackage

FILE: design/pvsw_if.sv
// ---------------------------------------------------------------------------
// Varint stream writer channels
// Input item channel and output byte channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface pvsw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] value;
  logic [7:0]  raw_byte;
  logic [2:0]  align_log2;

  modport source (output valid, kind, value, raw_byte, align_log2, input ready);
  modport sink   (input valid, kind, value, raw_byte, align_log2, output ready);
endinterface

interface pvsw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last;
  logic [63:0] byte_count;

  modport source (output valid, out_byte, last, byte_count, input ready);
  modport sink   (input valid, out_byte, last, byte_count, output ready);
endinterface

FILE: design/pvsw_front.sv
// ---------------------------------------------------------------------------
// Varint stream writer front end
// Accepts items, sizes varints and gaps, and pushes byte commands.
// ---------------------------------------------------------------------------
module pvsw_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  pvsw_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output pvsw_pkg::cmd_t   cmd_o
);
  import pvsw_pkg::*;

  logic [LenW-1:0] sched_q, sched_d;  // low bits of the byte count once queued work is sent
  logic            accept;
  logic [3:0]      extra;
  logic [2:0]      lg_eff;
  logic [LenW-1:0] pad_mask;
  logic [LenW-1:0] pad_len;
  cmd_t            cmd;
  logic            has_bytes;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Varint length from the highest nonzero 7-bit group.
  always_comb begin
    if (|in_i.value[63:56])      extra = 4'd8;
    else if (|in_i.value[55:49]) extra = 4'd7;
    else if (|in_i.value[48:42]) extra = 4'd6;
    else if (|in_i.value[41:35]) extra = 4'd5;
    else if (|in_i.value[34:28]) extra = 4'd4;
    else if (|in_i.value[27:21]) extra = 4'd3;
    else if (|in_i.value[20:14]) extra = 4'd2;
    else if (|in_i.value[13:7])  extra = 4'd1;
    else                         extra = 4'd0;
  end

  // Gap length from the count the stream will have reached.
  assign lg_eff   = (in_i.align_log2 > 3'(MaxAlignLog2)) ? 3'(MaxAlignLog2)
                                                          : in_i.align_log2;
  assign pad_mask = LenW'((7'd1 << lg_eff) - 7'd1);
  assign pad_len  = (LenW'(0) - sched_q) & pad_mask;

  always_comb begin
    cmd       = '0;
    has_bytes = 1'b0;
    case (in_i.kind)
      KIND_VARINT: begin
        has_bytes = 1'b1;
        cmd.len   = LenW'(extra) + LenW'(1);
        cmd.rest  = in_i.value << (7'd64 - {extra, 3'b000});
        case (extra)
          4'd0:    cmd.first = {1'b0, in_i.value[6:0]};
          4'd1:    cmd.first = {2'b10, in_i.value[13:8]};
          4'd2:    cmd.first = {3'b110, in_i.value[20:16]};
          4'd3:    cmd.first = {4'b1110, in_i.value[27:24]};
          4'd4:    cmd.first = {5'b11110, in_i.value[34:32]};
          4'd5:    cmd.first = {6'b111110, in_i.value[41:40]};
          4'd6:    cmd.first = {7'b1111110, in_i.value[48]};
          4'd7:    cmd.first = 8'hFE;
          default: cmd.first = 8'hFF;
        endcase
      end
      KIND_RAW: begin
        has_bytes = 1'b1;
        cmd.first = in_i.raw_byte;
        cmd.len   = LenW'(1);
      end
      KIND_PAD: begin
        // Drop a gap that is already aligned.
        has_bytes = (pad_len != '0);
        cmd.pad   = 1'b1;
        cmd.first = PadByte;
        cmd.len   = pad_len;
      end
      default: begin
        has_bytes = 1'b0;  // unused kind: drop
      end
    endcase
  end

  assign push_o  = accept && has_bytes;
  assign cmd_o   = cmd;
  assign sched_d = push_o ? sched_q + cmd.len : sched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_q <= '0;
    end else begin
      sched_q <= sched_d;
    end
  end

endmodule

FILE: design/pvsw_fifo.sv
// ---------------------------------------------------------------------------
// Varint stream writer command queue
// Small first-in first-out buffer between front end and byte sender.
// ---------------------------------------------------------------------------
module pvsw_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pvsw_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pvsw_pkg::cmd_t head_o
);
  import pvsw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/pvsw_back.sv
// ---------------------------------------------------------------------------
// Varint stream writer byte sender
// Plays queued commands out one byte per cycle while the output is ready and keeps the byte count.
// ---------------------------------------------------------------------------
`include "prefix_varint_stream_writer_defines.svh"

module pvsw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  pvsw_pkg::cmd_t cmd_i,
  output logic           pop_o,
  pvsw_out_if.source     out_o
);
  import pvsw_pkg::*;

  logic            busy_q, busy_d;
  cmd_t            cmd_q, cmd_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [63:0]     count_q, count_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            out_last_q;
  logic [63:0]     out_count_q;
  logic            out_adv, emit, is_last, done;
  logic [7:0]      cur_byte;

  assign out_adv  = !out_valid_q || out_o.ready;
  assign emit     = busy_q && out_adv;
  assign is_last  = (idx_q == cmd_q.len - LenW'(1));
  assign done     = emit && is_last;
  assign pop_o    = cmd_valid_i && (!busy_q || done);
  assign cur_byte = cmd_q.pad ? PadByte : ((idx_q == '0) ? cmd_q.first : cmd_q.rest[63:56]);
  assign count_d  = emit ? count_q + 64'd1 : count_q;

  always_comb begin
    busy_d      = busy_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    out_valid_d = out_o.ready ? 1'b0 : out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + LenW'(1);
      if (!cmd_q.pad && idx_q != '0) begin
        cmd_d.rest = {cmd_q.rest[55:0], 8'h00};
      end
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      out_byte_q  <= cur_byte;
      out_last_q  <= is_last;
      out_count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.last       = out_last_q;
  assign out_o.byte_count = out_count_q;

  `PVSW_ASSERT_NOW(a_idx_in_range, busy_q, idx_q < cmd_q.len, "byte index past command end")
  `PVSW_ASSERT_NOW(a_pop_when_free, pop_o, !busy_q || done, "command taken while busy")
  `PVSW_ASSERT_NEXT(a_count_step, emit, out_valid_q && count_q == $past(count_q) + 64'd1 && out_o.byte_count == count_q, "byte count not advanced with beat")

endmodule

FILE: design/prefix_varint_stream_writer.sv
// ---------------------------------------------------------------------------
// Prefix-length varint stream writer
// Serializes varints, raw bytes and alignment gaps into a counted byte stream.
// ---------------------------------------------------------------------------
// The output carries one byte per beat at up to one beat per clock, each
// tagged with the running 64-bit byte count (wrapping) and a last flag on the
// final byte of its item. An item yields as many output beats as it has
// bytes: 1 to 9 for a varint, 1 for a raw byte, 0 to 63 for a gap (gaps that
// are already aligned and kind 3 produce nothing and cost only the input
// beat). The byte sender sets the output rate; the input side keeps taking
// items into the command queue while bytes drain, so the first byte of an
// item passes through the queue, the sender's command register and the
// output register when the queue is empty, and consecutive items run without
// bubbles. QueueDepth sets how many sized items can wait ahead of the sender.
// ---------------------------------------------------------------------------
module prefix_varint_stream_writer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pvsw_in_if.sink    in_i,
  pvsw_out_if.source out_o
);
  import pvsw_pkg::*;

  // Front to queue.
  logic push;
  cmd_t push_cmd;
  logic full;

  // Queue to sender.
  logic cmd_valid;
  cmd_t head_cmd;
  logic pop;

  // Classify items, size varints and gaps; gap size uses the count the
  // stream will have once everything ahead of it is sent.
  pvsw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // Hold sized commands so either side can stall on its own.
  pvsw_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (cmd_valid),
    .head_o     (head_cmd)
  );

  // Send bytes, advance the running count, register the output beat.
  pvsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// Varint stream writer testbench
// Drives varint, raw-byte, gap and unused-kind items into the writer with
// random idling on both channels, predicts every output byte with its last
// flag and running count, and checks each byte in order as it is taken.
// ---------------------------------------------------------------------------
module testbench;
  import pvsw_pkg::*;

  // The package has no member for the fourth kind code; the block ignores it.
  localparam logic [1:0] KindUnused = 2'd3;

  localparam int unsigned DirectedGapLog2 = 3;
  localparam int unsigned RandomItems     = 150;
  localparam int unsigned HoldCycles      = 80;
  localparam int unsigned DrainCycles     = 20;
  localparam int unsigned WatchdogLimit   = 1000;

  // One byte of the output stream as the block should present it.
  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [63:0] count;
  } stream_byte_t;

  // Tracks the running byte count and the bytes still owed by the block.
  class varint_stream_tracker;
    stream_byte_t owed_bytes[$];
    logic [63:0]  bytes_written;
    int unsigned  mismatches;
    int unsigned  varints, raws, gaps, pad_bytes, bytes_checked;

    function new();
      bytes_written = '0;
      mismatches    = 0;
      varints       = 0;
      raws          = 0;
      gaps          = 0;
      pad_bytes     = 0;
      bytes_checked = 0;
    endfunction

    function int unsigned pending();
      return owed_bytes.size();
    endfunction

    // Append a run of bytes; the final one carries the last flag.
    function void owe_run(logic [7:0] run[$]);
      for (int i = 0; i < run.size(); i++) begin
        bytes_written += 64'd1;
        owed_bytes.push_back('{run[i], (i == run.size() - 1), bytes_written});
      end
    endfunction

    // Work out the bytes that one accepted item causes.
    function void note_item(logic [1:0] kind, logic [63:0] value, logic [7:0] raw,
                            logic [2:0] align_log2);
      logic [7:0]  run[$];
      int unsigned extra;
      int unsigned lg;
      logic [63:0] pad;
      case (kind)
        KIND_VARINT: begin
          varints++;
          // Count the extra bytes: each one buys seven more value bits.
          extra = 0;
          while (extra < 8 && value >= (64'd1 << (7 * (extra + 1)))) extra++;
          if (extra < 8) begin
            run.push_back(~(8'hFF >> extra) | 8'(value >> (8 * extra)));
          end else begin
            run.push_back(8'hFF);
          end
          for (int i = int'(extra) - 1; i >= 0; i--) run.push_back(8'(value >> (8 * i)));
        end
        KIND_RAW: begin
          raws++;
          run.push_back(raw);
        end
        KIND_PAD: begin
          gaps++;
          lg  = (align_log2 > MaxAlignLog2) ? MaxAlignLog2 : align_log2;
          pad = (64'd0 - bytes_written) & ((64'd1 << lg) - 64'd1);
          pad_bytes += int'(pad);
          for (int i = 0; i < int'(pad); i++) run.push_back(PadByte);
        end
        default: begin
        end
      endcase
      owe_run(run);
    endfunction

    // Compare one taken output byte with the oldest owed one.
    function void check_byte(logic [7:0] data, logic last, logic [63:0] count);
      stream_byte_t want;
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        $error("unexpected output byte %02h (last %0b, byte_count %0d)", data, last, count);
        mismatches++;
        return;
      end
      want = owed_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, data);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
      if (count !== want.count) begin
        $error("byte_count: expected %0d, actual %0d", want.count, count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pvsw_in_if  item_ch ();
  pvsw_out_if byte_ch ();

  prefix_varint_stream_writer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch.sink),
    .out_o  (byte_ch.source)
  );

  varint_stream_tracker tracker = new();

  bit          no_idle;     // last stretch: both sides run flat out
  bit          hold_sink;   // ask the byte side for one long hold-off
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watch both channels at the rising edge. Check taken bytes before noting
  // a new item so an item's own bytes can never be checked against itself.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        tracker.check_byte(byte_ch.out_byte, byte_ch.last, byte_ch.byte_count);
      end
      if (item_ch.valid && item_ch.ready) begin
        tracker.note_item(item_ch.kind, item_ch.value, item_ch.raw_byte,
                          item_ch.align_log2);
      end
      if ((byte_ch.valid && byte_ch.ready) || (item_ch.valid && item_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Byte side: mostly ready, with short random stalls, and one long hold
  // on request so the command queue fills and the input backs up.
  initial begin
    byte_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        hold_sink     = 1'b0;
        byte_ch.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        byte_ch.ready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        byte_ch.ready = 1'b1;
      end
    end
  end

  // Offer one item at a falling edge and hold it until the rising edge that
  // takes it; leave valid high so back-to-back items stream without gaps.
  task automatic send_item(logic [1:0] kind, logic [63:0] value, logic [7:0] raw,
                           logic [2:0] align_log2);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    item_ch.valid      = 1'b1;
    item_ch.kind       = kind;
    item_ch.value      = value;
    item_ch.raw_byte   = raw;
    item_ch.align_log2 = align_log2;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and wait at falling edges until every owed byte has come.
  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  // Random value with a random encoded length; now and then the exact low
  // edge of a length class.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int unsigned n;
    v = {$urandom, $urandom};
    n = $urandom_range(1, 9);
    if (n >= 2 && $urandom_range(0, 7) == 0) begin
      v = 64'd1 << (7 * (n - 1));
    end else if (n < 9) begin
      v = v & ((64'd1 << (7 * n)) - 64'd1);
    end
    return v;
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  kind;
    pick = $urandom_range(0, 99);
    if (pick < 70)      kind = KIND_VARINT;
    else if (pick < 85) kind = KIND_RAW;
    else if (pick < 97) kind = KIND_PAD;
    else                kind = KindUnused;
    // Fill the fields the kind does not use with noise as well.
    send_item(kind, random_value(), 8'($urandom), 3'($urandom_range(0, 7)));
  endtask

  initial begin
    logic [63:0] edge_value;
    int unsigned sent;

    item_ch.valid      = 1'b0;
    item_ch.kind       = KIND_VARINT;
    item_ch.value      = '0;
    item_ch.raw_byte   = '0;
    item_ch.align_log2 = '0;
    no_idle            = 1'b0;
    hold_sink          = 1'b0;
    quiet_cycles       = 0;

    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero, then both edges of every length class up to all ones.
    send_item(KIND_VARINT, 64'd0, 8'h00, 3'd0);
    for (int n = 1; n <= 9; n++) begin
      edge_value = (n < 9) ? (64'd1 << (7 * n)) - 64'd1 : '1;
      send_item(KIND_VARINT, edge_value, 8'h00, 3'd0);
      if (n < 9) send_item(KIND_VARINT, 64'd1 << (7 * n), 8'h00, 3'd0);
    end

    // Directed: raw extremes, a real gap, a saturated gap, then two gaps
    // that are already aligned, and the unused kind.
    send_item(KIND_RAW, '0, 8'h00, 3'd0);
    send_item(KIND_PAD, '0, 8'h00, 3'(DirectedGapLog2));
    send_item(KIND_RAW, '1, 8'hFF, 3'd7);
    send_item(KIND_PAD, '1, 8'hFF, 3'd7);
    send_item(KIND_PAD, '0, 8'h00, 3'(MaxAlignLog2));
    send_item(KIND_PAD, '0, 8'h00, 3'd0);
    send_item(KindUnused, '1, 8'hFF, 3'd7);

    // Random: ask for a long byte-side hold-off up front and keep offering
    // items into it, pause once for a full drain midway, and run the last
    // stretch with no idling on either side. Ignored items do not count.
    hold_sink = 1'b1;
    sent = 0;
    while (sent < RandomItems) begin
      if (sent == RandomItems / 2) wait_drained();
      no_idle = (sent >= RandomItems - 40);
      send_random_item();
      if (item_ch.kind != KindUnused) sent++;
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d varints, %0d raw bytes, %0d gaps with %0d pad bytes;",
             tracker.varints, tracker.raws, tracker.gaps, tracker.pad_bytes);
    $display("checked %0d output bytes through a long output stall and a full drain",
             tracker.bytes_checked);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
